// ----- rtl/sorted_priority_queue_top_assert.svh -----
// Assertion macros shared by the queue RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger in one cycle that requires a consequence in the next one.
`define SPQ_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int VALUE_W  = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ENTRY_W  = 5;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_SPARE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic                      ins;
    logic                      rem;
    logic signed [VALUE_W-1:0] value;
  } spq_op_t;

  // What a cell shows to its neighbours and to the control logic.
  typedef struct packed {
    logic                      valid;
    logic                      lt;
    logic                      eq;
    logic signed [VALUE_W-1:0] value;
  } spq_link_t;

endpackage

// ----- rtl/spq_in_if.sv -----
`timescale 1ns / 1ps

interface spq_in_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic signed [VALUE_W-1:0] item_value;

  modport source (output valid, func, item_value, input ready);
  modport sink (input valid, func, item_value, output ready);
endinterface

// ----- rtl/spq_out_if.sv -----
`timescale 1ns / 1ps

interface spq_out_if;
  import spq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] head_value;
  logic                      queue_empty;
  logic [ENTRY_W-1:0]        entry_count;

  modport source (output valid, status, head_value, queue_empty, entry_count, input ready);
  modport sink (input valid, status, head_value, queue_empty, entry_count, output ready);
endinterface

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spq_pkg::spq_op_t   op,
  input  spq_pkg::spq_link_t left,
  input  spq_pkg::spq_link_t right,
  output spq_pkg::spq_link_t self
);
  import spq_pkg::*;

  logic                      valid_r;
  logic                      valid_nxt;
  logic signed [VALUE_W-1:0] value_r;
  logic signed [VALUE_W-1:0] value_nxt;
  logic                      lt;

  assign lt = valid_r && (value_r < op.value);

  assign self.valid = valid_r;
  assign self.lt    = lt;
  assign self.eq    = valid_r && (value_r == op.value);
  assign self.value = value_r;

  // Insert: cells holding smaller values keep them, the first other cell takes the
  // new value and every cell after it takes its left neighbour's entry.
  // Remove: every cell from the matching entry onwards takes its right neighbour's.
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (op.ins && !lt) begin
      valid_nxt = valid_r | left.valid;
      value_nxt = left.lt ? op.value : left.value;
    end else if (op.rem && !lt) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ----- rtl/sorted_priority_queue_top.sv -----
`timescale 1ns / 1ps

// Channel   Role    Transaction carries
// in_if     sink    func, item_value
// out_if    source  status, head_value, queue_empty, entry_count
//
// One item is taken per cycle while results are taken: the row of cells compares and
// shifts in the cycle the transaction is accepted, so the rate is set by one pass through
// a cell. The result appears in the cycle after acceptance, from the status register and
// the updated cells. A new item is accepted while a result waits, provided that
// result is taken in the same cycle. Reset (rst_n low, synchronous) empties the queue.

module sorted_priority_queue_top (
  input  logic clk,
  input  logic rst_n,
  spq_in_if.sink    in_if,
  spq_out_if.source out_if
);
  import spq_pkg::*;

  `include "sorted_priority_queue_top_assert.svh"

  spq_link_t            links   [CAPACITY];
  spq_op_t              op;
  logic [CAPACITY-1:0]  eq_vec;
  logic [CAPACITY-1:0]  valid_vec;
  logic                 in_fire;
  logic                 found;
  logic                 full;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  status_t              status_r;
  status_t              status_nxt;
  logic [CNT_W+ENTRY_W-1:0] count_ext;

  // The boundary to the left of the first cell reads as a valid, smaller entry,
  // so an insert lands there when nothing stored is smaller. Beyond the last cell
  // the row reads as empty.
  localparam spq_link_t LEFT_EDGE  = '{valid: 1'b1, lt: 1'b1, eq: 1'b0, value: '0};
  localparam spq_link_t RIGHT_EDGE = '{valid: 1'b0, lt: 1'b0, eq: 1'b0, value: '0};

  assign in_fire = in_if.valid && in_if.ready;
  assign full    = (count_r == CNT_W'(CAPACITY));

  // Equal values sit together in sorted order, so any match means the first entry
  // not smaller than the key is a match, which is where the remove begins.
  assign found = |eq_vec;

  assign op.value = in_if.item_value;
  assign op.ins   = in_fire && (func_t'(in_if.func) == FUNC_INSERT) && !full;
  assign op.rem   = in_fire && (func_t'(in_if.func) == FUNC_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op    (op),
      .left  ((i == 0) ? LEFT_EDGE : links[(i == 0) ? 0 : i - 1]),
      .right ((i == CAPACITY - 1) ? RIGHT_EDGE : links[(i == CAPACITY - 1) ? i : i + 1]),
      .self  (links[i])
    );
    assign eq_vec[i]    = links[i].eq;
    assign valid_vec[i] = links[i].valid;
  end

  always_comb begin
    status_nxt = status_r;
    count_nxt  = count_r;
    if (in_fire) begin
      unique case (func_t'(in_if.func))
        FUNC_INSERT: begin
          if (full) begin
            status_nxt = STATUS_FULL;
          end else begin
            status_nxt = STATUS_OK;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        FUNC_REMOVE: begin
          if (found) begin
            status_nxt = STATUS_OK;
            count_nxt  = count_r - CNT_W'(1);
          end else begin
            status_nxt = STATUS_NOT_FOUND;
          end
        end
        default: begin
          // Find, and the spare code, which behaves the same.
          status_nxt = found ? STATUS_OK : STATUS_NOT_FOUND;
        end
      endcase
    end
  end

  assign in_if.ready   = !out_valid_r || out_if.ready;
  assign out_valid_nxt = in_fire || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  // The cells and the count change only when a transaction is accepted, which is
  // also when the previous result leaves, so the result can be read from them.
  assign count_ext          = {{ENTRY_W{1'b0}}, count_r};
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = status_r;
  assign out_if.head_value  = links[0].valid ? links[0].value : '0;
  assign out_if.queue_empty = (count_r == '0);
  assign out_if.entry_count = count_ext[ENTRY_W-1:0];

  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(CAPACITY), "entry count beyond capacity")
  `SPQ_ASSERT_ALWAYS(a_count_valid, $countones(valid_vec) == int'(count_r), "valid cells disagree with count")
  `SPQ_ASSERT_ALWAYS(a_head_valid, links[0].valid == (count_r != '0), "head cell occupancy wrong")
  `SPQ_ASSERT_NEXT(a_insert_grows, op.ins, count_r == $past(count_r) + CNT_W'(1), "insert did not grow queue")

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the sorted priority queue. Every transaction that
// is accepted on the input channel is replayed on a behavioural copy of the
// queue held here as an ordered list of values. The outcome is queued, and
// each result transaction is compared field by field with the oldest entry.
module tb;
  import spq_pkg::*;

  // One expected result, laid out like the output channel.
  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] head_value;
    logic                      queue_empty;
    logic [ENTRY_W-1:0]        entry_count;
  } queue_result_t;

  // One row of the directed table. Where has_fixed is set, the outcome is
  // obvious from the operation and is written out by hand. Otherwise the
  // row is checked against the behavioural queue.
  typedef struct packed {
    func_t                     func;
    logic signed [VALUE_W-1:0] value;
    logic                      has_fixed;
    queue_result_t             fixed;
  } stim_row_t;

  localparam int RANDOM_PER_PHASE = 400;
  localparam int QUIET_LIMIT      = 5000;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Behavioural copy of the queue, kept in ascending order, and the results
  // still owed by the block.
  logic signed [VALUE_W-1:0] held_vals[$];
  queue_result_t             pending_results[$];
  stim_row_t                 directed_rows[$];

  // A hand-written outcome travels alongside the transaction that it belongs to.
  logic          row_has_fixed;
  queue_result_t row_fixed;

  int fail_count     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Applies one operation to the behavioural queue and returns what the block
  // should report afterwards.
  function automatic queue_result_t apply_queue_op(logic [1:0] func,
                                                   logic signed [VALUE_W-1:0] value);
    queue_result_t res;
    int            hit;
    int            pos;
    hit = -1;
    pos = 0;
    foreach (held_vals[i]) begin
      if (hit < 0 && held_vals[i] == value) hit = i;
    end
    res.status = STATUS_OK;
    case (func)
      FUNC_INSERT: begin
        if (held_vals.size() >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          while (pos < held_vals.size() && held_vals[pos] < value) pos++;
          held_vals.insert(pos, value);
        end
      end
      FUNC_REMOVE: begin
        if (hit < 0) res.status = STATUS_NOT_FOUND;
        else held_vals.delete(hit);
      end
      // The spare code behaves as a find.
      default: begin
        if (hit < 0) res.status = STATUS_NOT_FOUND;
      end
    endcase
    res.queue_empty = (held_vals.size() == 0);
    res.head_value  = (held_vals.size() != 0) ? held_vals[0] : '0;
    res.entry_count = ENTRY_W'(held_vals.size());
    return res;
  endfunction

  function automatic void add_row(func_t func, logic signed [VALUE_W-1:0] value,
                                  logic has_fixed, status_t status,
                                  logic signed [VALUE_W-1:0] head, logic empty,
                                  int count);
    stim_row_t row;
    row.func               = func;
    row.value              = value;
    row.has_fixed          = has_fixed;
    row.fixed.status       = status;
    row.fixed.head_value   = head;
    row.fixed.queue_empty  = empty;
    row.fixed.entry_count  = ENTRY_W'(count);
    directed_rows.push_back(row);
  endfunction

  // In fill mode inserts dominate, so the queue runs up against its capacity.
  // In drain mode removes dominate and the queue tends towards empty.
  function automatic func_t pick_func(bit fill_mode);
    int r;
    r = $urandom_range(99);
    if (r < 5) return FUNC_SPARE;
    if (r < 20) return FUNC_FIND;
    if (fill_mode) return (r < 75) ? FUNC_INSERT : FUNC_REMOVE;
    return (r < 45) ? FUNC_INSERT : FUNC_REMOVE;
  endfunction

  // Values mostly come from a narrow band or from what the queue already holds,
  // so that duplicates, hits on remove and hits on find are common.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(16)) - 8;
      4, 5, 6: begin
        if (held_vals.size() != 0) return held_vals[$urandom_range(held_vals.size() - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  // Offers one transaction, with an optional gap before it, and holds it until
  // it is taken.
  task automatic offer_item(func_t func, logic signed [VALUE_W-1:0] value,
                            logic has_fixed, queue_result_t fixed);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.item_value <= $urandom;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= func;
    in_ch.item_value <= value;
    row_has_fixed    <= has_fixed;
    row_fixed        <= fixed;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops sending until every outstanding result has been taken.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // The receiver is ready at random, according to the stall rate of the
  // current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both channels are watched at every edge. The prediction is queued before
  // the result is checked, so a transaction is handled correctly whatever the
  // latency of the block.
  always @(posedge clk) begin
    queue_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = apply_queue_op(in_ch.func, in_ch.item_value);
        pending_results.push_back(row_has_fixed ? row_fixed : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with no expectation waiting");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.head_value !== want.head_value) begin
            $error("head_value: expected %0d, got %0d", want.head_value, out_ch.head_value);
            fail_count++;
          end
          if (out_ch.queue_empty !== want.queue_empty) begin
            $error("queue_empty: expected %0d, got %0d", want.queue_empty,
                   out_ch.queue_empty);
            fail_count++;
          end
          if (out_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_ch.entry_count);
            fail_count++;
          end
        end
      end
    end
  end

  // The watchdog ends a run in which no transaction moves on either side for
  // too long.
  always @(posedge clk) begin
    if (rst_n && !((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end else begin
      quiet_cycles <= 0;
    end
  end

  initial begin
    queue_result_t none;
    bit            fill_mode;
    none      = '0;
    fill_mode = 1'b1;

    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FUNC_INSERT;
    in_ch.item_value <= '0;
    row_has_fixed    <= 1'b0;
    row_fixed        <= '0;

    // The directed table. It starts on the empty queue: find, remove and the
    // spare code all miss there. Both extremes are then stored and found, and the
    // smallest is duplicated. After that, the queue is filled to capacity, and one more
    // insert is dropped.
    add_row(FUNC_FIND,   32'sh0000_0000, 1, STATUS_NOT_FOUND, 0, 1, 0);
    add_row(FUNC_REMOVE, 32'sh0000_0005, 1, STATUS_NOT_FOUND, 0, 1, 0);
    add_row(FUNC_SPARE,  32'sh0000_0000, 1, STATUS_NOT_FOUND, 0, 1, 0);
    add_row(FUNC_INSERT, 32'sh7fff_ffff, 1, STATUS_OK, 32'sh7fff_ffff, 0, 1);
    add_row(FUNC_INSERT, 32'sh8000_0000, 1, STATUS_OK, 32'sh8000_0000, 0, 2);
    add_row(FUNC_FIND,   32'sh8000_0000, 1, STATUS_OK, 32'sh8000_0000, 0, 2);
    add_row(FUNC_SPARE,  32'sh7fff_ffff, 1, STATUS_OK, 32'sh8000_0000, 0, 2);
    add_row(FUNC_INSERT, 32'sh8000_0000, 1, STATUS_OK, 32'sh8000_0000, 0, 3);
    add_row(FUNC_REMOVE, 32'sh8000_0000, 1, STATUS_OK, 32'sh8000_0000, 0, 2);
    for (int i = 1; i <= 13; i++) begin
      add_row(FUNC_INSERT, 32'(i * 32'h1234_5679), 0, STATUS_OK, 0, 0, 0);
    end
    add_row(FUNC_INSERT, 32'sh7fff_ffff, 1, STATUS_OK, 32'sh8000_0000, 0, CAPACITY);
    add_row(FUNC_INSERT, 32'sh0000_0000, 1, STATUS_FULL, 32'sh8000_0000, 0, CAPACITY);
    add_row(FUNC_FIND,   32'sh0000_3039, 0, STATUS_OK, 0, 0, 0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].func, directed_rows[i].value,
                 directed_rows[i].has_fixed, directed_rows[i].fixed);
    end
    drain_results();

    // Random phases: no idling, a slow sender, a slow receiver, then both
    // sides at a light rate. Between phases the sender waits until every
    // outstanding result has been taken.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if ($urandom_range(39) == 0) fill_mode = !fill_mode;
        offer_item(pick_func(fill_mode), pick_value(), 1'b0, none);
      end
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
